/* rtl/rira_pkg.sv */
// Shared constants, types and a helper function of the running average block.
package rira_pkg;

  localparam int unsigned RiraMaxElements = 1024;

  localparam int unsigned IdxW  = 10;
  localparam int unsigned ValW  = 32;
  localparam int unsigned DimW  = 11;
  localparam int unsigned IvlW  = 16;
  localparam int unsigned CfgAw = 2;
  localparam int unsigned CfgDw = 16;
  localparam int unsigned MagW  = 48;
  localparam int unsigned DvsW  = 17;

  localparam logic [CfgAw-1:0] CfgDimInUse        = 2'd0;
  localparam logic [CfgAw-1:0] CfgRestartInterval = 2'd1;

  localparam logic [DimW-1:0] DimReset = 11'd1024;
  localparam logic [IvlW-1:0] IvlReset = 16'd16;

  typedef struct packed {
    logic            start;
    logic            neg;
    logic [MagW-1:0] mag;
    logic [DvsW-1:0] divisor;
  } rira_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rira_div_sts_t;

  // reduce an element index modulo a constant depth by compare and subtract
  function automatic logic [IdxW-1:0] mod_index(logic [IdxW-1:0] x, int unsigned m);
    logic [IdxW:0] r;
    int unsigned   sh;
    r = {1'b0, x};
    for (int k = IdxW - 1; k >= 0; k--) begin
      sh = m << k;
      if (sh <= 1023) begin
        if (32'(r) >= sh) begin
          r = r - (IdxW + 1)'(sh);
        end
      end
    end
    return r[IdxW-1:0];
  endfunction

endpackage

/* rtl/rira_mem.sv */
// Single-port-write, single-port-read average store with registered read data.
module rira_mem import rira_pkg::*; #(
  parameter int unsigned Depth = RiraMaxElements,
  parameter int unsigned AddrW = 10
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic signed [ValW-1:0] wdata_i,
  input  logic                   re_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic signed [ValW-1:0] rdata_o
);

  logic signed [ValW-1:0] mem_q [Depth];
  logic signed [ValW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rira_div.sv */
// Radix-2 restoring divider, 48-bit magnitude by 17-bit divisor, signed 32-bit quotient.
module rira_div import rira_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rira_div_req_t          req_i,
  output rira_div_sts_t          sts_o,
  output logic signed [ValW-1:0] quot_o
);

  logic [DvsW-1:0] rem_q, rem_d;
  logic [ValW-1:0] sh_q, sh_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic            neg_q, neg_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DvsW:0]   trial;
  logic            ge;

  assign trial = {rem_q, sh_q[ValW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = {1'b0, req_i.mag[MagW-1:ValW]};
      sh_d   = req_i.mag[ValW-1:0];
      dvs_d  = req_i.divisor;
      neg_d  = req_i.neg;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DvsW'(trial - {1'b0, dvs_q}) : trial[DvsW-1:0];
      sh_d  = {sh_q[ValW-2:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = neg_q ? $signed(-sh_q) : $signed(sh_q);

endmodule

/* rtl/iterate_running_average_restart.sv */
// Top level: per-element cumulative average with periodic restart, store and sequencer.
//
// One element is taken at a time and delivered when the output register is
// free, and the next element can be taken in the cycle after delivery: a read of
// the average store, one 32x17 multiply, one wide add and a 32-step restoring
// divide by the pass count plus one, which sets the rate, then the write back.
// A new element may be accepted while the previous result still waits in the
// output register. After reset and after the last element of each restart pass
// the store is cleared one entry per cycle, all MaxElements entries (1024 by
// default), during which no element is accepted; configuration writes
// are taken at any time but must only be issued while the block is idle.
module iterate_running_average_restart import rira_pkg::*; #(
  parameter int unsigned MaxElements = RiraMaxElements
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgAw-1:0]       cfg_index_i,
  input  logic [CfgDw-1:0]       cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [IdxW-1:0]        element_index_i,
  input  logic signed [ValW-1:0] value_in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [ValW-1:0] value_out_o,
  output logic                   is_average_o,
  output logic                   pass_end_o
);

  localparam int unsigned AddrW = (MaxElements > 1) ? $clog2(MaxElements) : 1;
  localparam logic [DimW-1:0] DimCap =
    (MaxElements < 2047) ? DimW'(MaxElements) : 11'd2047;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MaxElements - 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StAdd   = 3'd3;
  localparam logic [2:0] StStart = 3'd4;
  localparam logic [2:0] StWait  = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;
  localparam logic [2:0] StClear = 3'd7;

  logic [2:0]             st_q, st_d;
  logic [AddrW-1:0]       clr_q, clr_d;
  logic [DimW-1:0]        dim_q, dim_d;
  logic [IvlW-1:0]        ivl_q, ivl_d;
  logic [IvlW-1:0]        pc_q, pc_d;
  logic                   out_valid_q, out_valid_d;

  logic [AddrW-1:0]       idx_q, idx_d;
  logic [IdxW-1:0]        raw_q, raw_d;
  logic signed [ValW-1:0] v_q, v_d;
  logic signed [48:0]     prod_q, prod_d;
  logic signed [49:0]     acc_q, acc_d;
  logic signed [ValW-1:0] vout_q, vout_d;
  logic                   avg_flag_q, avg_flag_d;
  logic                   pend_q, pend_d;

  logic                   mem_we;
  logic [AddrW-1:0]       mem_waddr;
  logic signed [ValW-1:0] mem_wdata;
  logic signed [ValW-1:0] mem_rdata;
  logic                   mem_re;

  rira_div_req_t          div_req;
  rira_div_sts_t          div_sts;
  logic signed [ValW-1:0] quot;
  logic [49:0]            acc_neg;

  logic [DimW-1:0]        dim_eff;
  logic [IvlW-1:0]        ivl_eff;
  logic [IvlW:0]          pc_inc;
  logic                   restart;
  logic                   last;
  logic                   in_acc;

  rira_mem #(
    .Depth (MaxElements),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  rira_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts),
    .quot_o (quot)
  );

  assign dim_eff = (dim_q == '0) ? 11'd1 : ((dim_q > DimCap) ? DimCap : dim_q);
  assign ivl_eff = (ivl_q == '0) ? 16'd1 : ivl_q;
  assign pc_inc  = {1'b0, pc_q} + 17'd1;
  assign restart = pc_inc >= {1'b0, ivl_eff};
  assign last    = {1'b0, raw_q} == (dim_eff - 11'd1);

  assign acc_neg         = -acc_q;
  assign div_req.start   = (st_q == StStart);
  assign div_req.neg     = acc_q[49];
  assign div_req.mag     = acc_q[49] ? acc_neg[MagW-1:0] : acc_q[MagW-1:0];
  assign div_req.divisor = pc_inc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign mem_re      = (st_q == StRead);

  always_comb begin
    st_d        = st_q;
    clr_d       = clr_q;
    dim_d       = dim_q;
    ivl_d       = ivl_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    raw_d       = raw_q;
    v_d         = v_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    vout_d      = vout_q;
    avg_flag_d  = avg_flag_q;
    pend_d      = pend_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = quot;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDimInUse:        dim_d = cfg_data_i[DimW-1:0];
        CfgRestartInterval: ivl_d = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (st_q)
      StIdle: begin
        if (in_acc) begin
          idx_d = AddrW'(mod_index(element_index_i, MaxElements));
          raw_d = element_index_i;
          v_d   = value_in_i;
          st_d  = StRead;
        end
      end
      StRead: st_d = StMul;
      StMul: begin
        prod_d = 49'(mem_rdata) * 49'($signed({1'b0, pc_q}));
        st_d   = StAdd;
      end
      StAdd: begin
        acc_d = {prod_q[48], prod_q} + {{18{v_q[ValW-1]}}, v_q};
        st_d  = StStart;
      end
      StStart: st_d = StWait;
      StWait: begin
        if (div_sts.done) begin
          st_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          mem_we      = 1'b1;
          out_valid_d = 1'b1;
          vout_d      = restart ? quot : v_q;
          avg_flag_d  = restart;
          pend_d      = last;
          st_d        = StIdle;
          if (last) begin
            if (restart) begin
              pc_d  = '0;
              clr_d = '0;
              st_d  = StClear;
            end else begin
              pc_d = pc_inc[IvlW-1:0];
            end
          end
        end
      end
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == LastAddr) begin
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StClear;
      clr_q       <= '0;
      dim_q       <= DimReset;
      ivl_q       <= IvlReset;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      dim_q       <= dim_d;
      ivl_q       <= ivl_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    raw_q      <= raw_d;
    v_q        <= v_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    vout_q     <= vout_d;
    avg_flag_q <= avg_flag_d;
    pend_q     <= pend_d;
  end

  assign out_valid_o  = out_valid_q;
  assign value_out_o  = vout_q;
  assign is_average_o = avg_flag_q;
  assign pass_end_o   = pend_q;

endmodule

/* rtl/rira_checker.sv */
// Port-level checker of the running average block and its bind.
module rira_checker import rira_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic signed [ValW-1:0] value_out_o,
  input logic                   is_average_o,
  input logic                   pass_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_out_o)
      && $stable(is_average_o) && $stable(pass_end_o))
    else $error("result changed or dropped while stalled");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted in consecutive cycles");

  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("request ready before store clear finished");

  a_clear_after_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && is_average_o && pass_end_o |-> !in_ready_o)
    else $error("request ready right after restart pass ended");

endmodule

bind iterate_running_average_restart rira_checker u_rira_checker (.*);
